[src/midi_fader_cc_nrpn_translator_unit_defines.svh]
// Assertion macros shared by the fader translator RTL.
// Included by the top level; no other dependencies.
`ifndef MIDI_FADER_CC_NRPN_TRANSLATOR_UNIT_DEFINES_SVH
`define MIDI_FADER_CC_NRPN_TRANSLATOR_UNIT_DEFINES_SVH

// Combinational check, sampled at every rising clock edge outside reset.
`define MFCN_ASSERT_NOW(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("fader translator check failed");

// Implication check, sampled at every rising clock edge outside reset.
`define MFCN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fader translator check failed");

`endif

[src/mfcn_pkg.sv]
// Package for the fader CC/NRPN translator: port and controller codes,
// register indexes, the job record passed from front to back, and queue sizing.
package mfcn_pkg;

  // Ports of the translator.
  localparam logic [1:0] PORT_FADER  = 2'd0;
  localparam logic [1:0] PORT_DAW    = 2'd1;
  localparam logic [1:0] PORT_PLUGIN = 2'd2;
  localparam logic [1:0] PORT_OTHER  = 2'd3;

  // Controller numbers.
  localparam logic [6:0] CC_VALUE_MSB = 7'd0;
  localparam logic [6:0] CC_VALUE_LSB = 7'd32;
  localparam logic [6:0] CC_TOUCH     = 7'd47;
  localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
  localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
  localparam logic [6:0] CC_DATA_LSB  = 7'd38;
  localparam logic [6:0] CC_DATA_MSB  = 7'd6;
  localparam logic [6:0] NRPN_PARAM_MSB = 7'd0;

  // Configuration port.
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 7;
  localparam logic [CFG_IW-1:0] CFG_IDX_CHANNEL = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IDX_PARAM   = 2'd1;
  localparam logic [3:0] CHANNEL_RESET   = 4'd0;
  localparam logic [6:0] PARAM_LSB_RESET = 7'd1;

  // Job queue between front and back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Step counter of the back end: longest run is eight messages.
  localparam int unsigned STEP_W = 3;

  typedef enum logic [1:0] {
    JK_NRPN  = 2'd0,  // fader position to both hosts, eight messages
    JK_TOUCH = 2'd1,  // touch forwarded to both hosts, two messages
    JK_HOST  = 2'd2   // host position to fader, two messages
  } job_kind_e;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] param_lsb;
  } cfg_t;

  typedef struct packed {
    job_kind_e  kind;
    logic [6:0] val_a;  // first value sent (already inverted where needed)
    logic [6:0] val_b;  // second value sent
  } job_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [FIFO_CW-1:0] count;
  } fifo_status_t;

endpackage

[src/mfcn_front.sv]
// Front end of the fader translator: accepts messages, tracks the fader and
// host pairing state, and pushes one job per message that produces output. Uses mfcn_pkg.
module mfcn_front import mfcn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] src_port_i,
  input  logic [3:0] channel_i,
  input  logic       is_control_change_i,
  input  logic [6:0] cc_number_i,
  input  logic [6:0] data_value_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output job_t       push_job_o
);

  logic [6:0] fader_msb_q, fader_msb_d;
  logic       fader_msb_valid_q, fader_msb_valid_d;
  logic [6:0] host_lsb_q, host_lsb_d;
  logic       host_lsb_valid_q, host_lsb_valid_d;
  logic       nrpn_selected_q, nrpn_selected_d;
  logic       accept;
  logic       hit;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign hit        = is_control_change_i && (channel_i == cfg_i.channel);

  always_comb begin
    fader_msb_d       = fader_msb_q;
    fader_msb_valid_d = fader_msb_valid_q;
    host_lsb_d        = host_lsb_q;
    host_lsb_valid_d  = host_lsb_valid_q;
    nrpn_selected_d   = nrpn_selected_q;
    push_o            = 1'b0;
    push_job_o.kind   = JK_TOUCH;
    push_job_o.val_a  = data_value_i;
    push_job_o.val_b  = data_value_i;
    if (accept && hit) begin
      case (src_port_i)
        PORT_FADER: begin
          if (cc_number_i == CC_VALUE_MSB) begin
            fader_msb_d       = data_value_i;
            fader_msb_valid_d = 1'b1;
          end else if (cc_number_i == CC_VALUE_LSB && fader_msb_valid_q) begin
            push_o            = 1'b1;
            push_job_o.kind   = JK_NRPN;
            push_job_o.val_a  = ~data_value_i;
            push_job_o.val_b  = ~fader_msb_q;
            fader_msb_valid_d = 1'b0;
          end else if (cc_number_i == CC_TOUCH) begin
            push_o = 1'b1;
          end
        end
        PORT_DAW, PORT_PLUGIN: begin
          if (cc_number_i == CC_NRPN_LSB && data_value_i == cfg_i.param_lsb) begin
            nrpn_selected_d = 1'b1;
          end else if (cc_number_i == CC_DATA_LSB && nrpn_selected_q) begin
            host_lsb_d       = data_value_i;
            host_lsb_valid_d = 1'b1;
          end else if (cc_number_i == CC_DATA_MSB && host_lsb_valid_q) begin
            push_o           = 1'b1;
            push_job_o.kind  = JK_HOST;
            push_job_o.val_a = ~data_value_i;
            push_job_o.val_b = ~host_lsb_q;
            host_lsb_valid_d = 1'b0;
            nrpn_selected_d  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fader_msb_q       <= '0;
      fader_msb_valid_q <= 1'b0;
      host_lsb_q        <= '0;
      host_lsb_valid_q  <= 1'b0;
      nrpn_selected_q   <= 1'b0;
    end else begin
      fader_msb_q       <= fader_msb_d;
      fader_msb_valid_q <= fader_msb_valid_d;
      host_lsb_q        <= host_lsb_d;
      host_lsb_valid_q  <= host_lsb_valid_d;
      nrpn_selected_q   <= nrpn_selected_d;
    end
  end

endmodule

[src/mfcn_fifo.sv]
// Short job queue between the front and back ends of the fader translator.
// Uses mfcn_pkg for the job record and depth.
module mfcn_fifo import mfcn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  job_t         push_job_i,
  input  logic         pop_i,
  output job_t         head_o,
  output fifo_status_t status_o
);

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;

  assign head_o          = mem_q[rd_ptr_q];
  assign status_o.empty  = (count_q == '0);
  assign status_o.full   = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign status_o.count  = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/mfcn_back.sv]
// Back end of the fader translator: walks the head job one message per cycle, unless
// the output stalls, into the output register. Uses mfcn_pkg.
module mfcn_back import mfcn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  job_t         job_i,
  input  fifo_status_t status_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [1:0]   dest_port_o,
  output logic [3:0]   out_channel_o,
  output logic [6:0]   out_cc_number_o,
  output logic [6:0]   out_value_o,
  output logic         last_of_run_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        dest_port_q;
  logic [3:0]        out_channel_q;
  logic [6:0]        out_cc_number_q;
  logic [6:0]        out_value_q;
  logic              last_of_run_q;
  logic              load_en;
  logic              advance;
  logic [1:0]        port_c;
  logic [6:0]        cc_c;
  logic [6:0]        val_c;
  logic              last_c;

  assign load_en = !out_valid_q || !out_stall_i;
  assign advance = load_en && !status_i.empty;

  // Message for the current step of the head job.
  always_comb begin
    port_c = PORT_FADER;
    cc_c   = CC_VALUE_MSB;
    val_c  = job_i.val_a;
    last_c = 1'b0;
    case (job_i.kind)
      JK_NRPN: begin
        port_c = step_q[2] ? PORT_PLUGIN : PORT_DAW;
        last_c = (step_q == '1);
        case (step_q[1:0])
          2'd0: begin
            cc_c  = CC_NRPN_MSB;
            val_c = NRPN_PARAM_MSB;
          end
          2'd1: begin
            cc_c  = CC_NRPN_LSB;
            val_c = cfg_i.param_lsb;
          end
          2'd2: begin
            cc_c  = CC_DATA_LSB;
            val_c = job_i.val_a;
          end
          default: begin
            cc_c  = CC_DATA_MSB;
            val_c = job_i.val_b;
          end
        endcase
      end
      JK_TOUCH: begin
        port_c = step_q[0] ? PORT_PLUGIN : PORT_DAW;
        cc_c   = CC_TOUCH;
        val_c  = job_i.val_a;
        last_c = step_q[0];
      end
      JK_HOST: begin
        port_c = PORT_FADER;
        cc_c   = step_q[0] ? CC_VALUE_LSB : CC_VALUE_MSB;
        val_c  = step_q[0] ? job_i.val_b : job_i.val_a;
        last_c = step_q[0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (load_en) begin
      out_valid_d = !status_i.empty;
    end
    if (advance) begin
      if (last_c) begin
        step_d = '0;
        pop_o  = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dest_port_q     <= port_c;
      out_channel_q   <= cfg_i.channel;
      out_cc_number_q <= cc_c;
      out_value_q     <= val_c;
      last_of_run_q   <= last_c;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dest_port_o     = dest_port_q;
  assign out_channel_o   = out_channel_q;
  assign out_cc_number_o = out_cc_number_q;
  assign out_value_o     = out_value_q;
  assign last_of_run_o   = last_of_run_q;

endmodule

[src/midi_fader_cc_nrpn_translator_unit.sv]
// Fader CC/NRPN translator top level: config registers, front, job queue, back.
// The first message of a transaction passes through the job queue and then the output
// register before it is valid. The back end sends one message per cycle unless the
// output stalls; a fader position yields eight messages, touch and host positions two.
// Reset: asynchronous, active low; clears pairing state, queue, and output valid.
module midi_fader_cc_nrpn_translator_unit import mfcn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  // Input message channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        src_port_i,
  input  logic [3:0]        channel_i,
  input  logic              is_control_change_i,
  input  logic [6:0]        cc_number_i,
  input  logic [6:0]        data_value_i,
  // Output message channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        dest_port_o,
  output logic [3:0]        out_channel_o,
  output logic [6:0]        out_cc_number_o,
  output logic [6:0]        out_value_o,
  output logic              last_of_run_o
);

  `include "midi_fader_cc_nrpn_translator_unit_defines.svh"

  // Configuration registers. Writes are always taken. The host must write only while
  // idle, which the block does not enforce, so both halves see one consistent setting.
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_CHANNEL: cfg_d.channel   = cfg_data_i[3:0];
        CFG_IDX_PARAM:   cfg_d.param_lsb = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel   <= CHANNEL_RESET;
      cfg_q.param_lsb <= PARAM_LSB_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each transaction and updates the fader and host pairing
  // state at once, so the next message can enter the following cycle unless the job
  // queue is full. Only messages that produce output leave a job in the queue.
  logic         push;
  job_t         push_job;
  logic         pop;
  job_t         head_job;
  fifo_status_t q_status;

  mfcn_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .src_port_i          (src_port_i),
    .channel_i           (channel_i),
    .is_control_change_i (is_control_change_i),
    .cc_number_i         (cc_number_i),
    .data_value_i        (data_value_i),
    .queue_full_i        (q_status.full),
    .push_o              (push),
    .push_job_o          (push_job)
  );

  mfcn_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .status_o   (q_status)
  );

  // The back end expands the head job into its run of messages, one per
  // cycle, through a registered output stage that holds under stall.
  mfcn_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .job_i           (head_job),
    .status_i        (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dest_port_o     (dest_port_o),
    .out_channel_o   (out_channel_o),
    .out_cc_number_o (out_cc_number_o),
    .out_value_o     (out_value_o),
    .last_of_run_o   (last_of_run_o)
  );

  // The queue count never exceeds its depth.
  `MFCN_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, q_status.count <= FIFO_CW'(FIFO_DEPTH))
  // Nothing is ever sent to the unused port code.
  `MFCN_ASSERT_IMP(a_dest_legal, clk_i, rst_ni, out_valid_o, dest_port_o != PORT_OTHER)
  // A run to the fader always ends on its LSB controller.
  `MFCN_ASSERT_IMP(a_fader_tail, clk_i, rst_ni,
                   out_valid_o && last_of_run_o && dest_port_o == PORT_FADER,
                   out_cc_number_o == CC_VALUE_LSB)
  // A run to the hosts always ends on the plugin port.
  `MFCN_ASSERT_IMP(a_host_tail, clk_i, rst_ni,
                   out_valid_o && last_of_run_o && dest_port_o != PORT_FADER,
                   dest_port_o == PORT_PLUGIN)

endmodule
